// ===== rtl/redeye_ir_frame_transmitter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the infrared frame transmitter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef REDEYE_IR_FRAME_TRANSMITTER_ASSERT_SVH
`define REDEYE_IR_FRAME_TRANSMITTER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define IRTX_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IRTX_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IRTX_ASSERT_SAME(name, clk, rst_n, ante, cons, msg)
`define IRTX_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/irtx_pkg.sv =====
// ----------------------------------------------------------------------------
// irtx_pkg
// Shared types, constants and helper functions of the IR frame transmitter.
// ----------------------------------------------------------------------------
package irtx_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int DATA_W  = 8;
    localparam int FRAME_W = 12;
    localparam int COUNT_W = 6;

    localparam logic [COUNT_W-1:0] LOAD_COUNT = 6'd60;
    localparam logic [COUNT_W-1:0] START_TOP  = 6'd54;
    localparam logic [COUNT_W-1:0] START_END  = 6'd48;

    localparam logic [DATA_W-1:0] PAR_MASK_3 = 8'h78;
    localparam logic [DATA_W-1:0] PAR_MASK_2 = 8'he6;
    localparam logic [DATA_W-1:0] PAR_MASK_1 = 8'hd5;
    localparam logic [DATA_W-1:0] PAR_MASK_0 = 8'h8b;

    typedef enum logic
    {
        CMD_TICK = 1'b0,
        CMD_PUT  = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed
    {
        logic burst;
        logic active;
    } slot_status_t;

    // Ring pointer advance with wrap at the queue depth.
    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(QUEUE_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    // Eight data bits below four even-parity bits.
    function automatic logic [FRAME_W-1:0] build_frame(input logic [DATA_W-1:0] d);
        logic [FRAME_W-1:0] f;
        f = {^(d & PAR_MASK_3), ^(d & PAR_MASK_2), ^(d & PAR_MASK_1),
             ^(d & PAR_MASK_0), d};
        return f;
    endfunction

endpackage

// ===== rtl/irtx_if.sv =====
// ----------------------------------------------------------------------------
// irtx_if
// Valid/ready channels for requests into and results out of the transmitter.
// ----------------------------------------------------------------------------
interface irtx_cmd_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface irtx_res_if;
    logic valid;
    logic ready;
    logic burst_on;
    logic frame_active;
    logic put_refused;

    modport source (output valid, output burst_on, output frame_active,
                    output put_refused, input ready);
    modport sink   (input valid, input burst_on, input frame_active,
                    input put_refused, output ready);
endinterface

// ===== rtl/redeye_ir_frame_transmitter.sv =====
// ----------------------------------------------------------------------------
// redeye_ir_frame_transmitter
// Queues bytes and sends them as parity-protected IR frames, one slot a tick.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload                               | Per request
//  cmd     | in        | command, data_byte                    | one tick or one put
//  res     | out       | burst_on, frame_active, put_refused   | one result
//
//  A request is registered on acceptance and resolved into the result
//  register, and one request is taken every cycle while the result is not
//  stalled. The result register and input register together keep the flow
//  going while a result waits; a stalled result holds the input register.
//  Reset clears the queue pointers, the slot counter and the carrier level.
// ----------------------------------------------------------------------------
`include "redeye_ir_frame_transmitter_assert.svh"

module redeye_ir_frame_transmitter
(
    input  logic       clk,
    input  logic       rst_n,
    irtx_cmd_if.sink   cmd,
    irtx_res_if.source res
);

    logic                         in_valid_reg;
    logic                         in_cmd_reg;
    logic [irtx_pkg::DATA_W-1:0]  in_data_reg;
    logic                         out_valid_reg;
    logic                         out_burst_reg;
    logic                         out_active_reg;
    logic                         out_refused_reg;

    logic                         advance;
    logic                         fire;
    logic                         do_put;
    logic                         do_tick;
    logic                         pop;
    logic [irtx_pkg::DATA_W-1:0]  q_head;
    irtx_pkg::queue_status_t      q_status;
    irtx_pkg::slot_status_t       s_status;

    assign advance   = !out_valid_reg || res.ready;
    assign fire      = in_valid_reg && advance;
    assign do_put    = fire && (in_cmd_reg == irtx_pkg::CMD_PUT);
    assign do_tick   = fire && (in_cmd_reg == irtx_pkg::CMD_TICK);
    assign cmd.ready = !in_valid_reg || advance;

    irtx_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .put      (do_put),
        .put_data (in_data_reg),
        .pop      (pop),
        .status   (q_status),
        .head     (q_head)
    );

    irtx_slot_seq u_slot_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (do_tick),
        .q_status (q_status),
        .q_head   (q_head),
        .pop      (pop),
        .status   (s_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_cmd_reg  <= cmd.command;
            in_data_reg <= cmd.data_byte;
        end
        if (fire)
        begin
            out_burst_reg   <= s_status.burst;
            out_active_reg  <= s_status.active;
            out_refused_reg <= do_put && q_status.full;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.burst_on     = out_burst_reg;
    assign res.frame_active = out_active_reg;
    assign res.put_refused  = out_refused_reg;

    `IRTX_ASSERT_SAME(a_pop_not_empty, clk, rst_n, pop, !q_status.empty, "pop from empty queue")
    `IRTX_ASSERT_SAME(a_burst_in_frame, clk, rst_n, res.valid && res.burst_on, res.frame_active, "burst outside a frame")
    `IRTX_ASSERT_NEXT(a_put_fills, clk, rst_n, do_put && !q_status.full, !q_status.empty, "accepted put left queue empty")

endmodule

// ===== rtl/irtx_queue.sv =====
// ----------------------------------------------------------------------------
// irtx_queue
// Byte ring buffer that holds one entry fewer than its depth.
// ----------------------------------------------------------------------------
module irtx_queue
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                put,
    input  logic [irtx_pkg::DATA_W-1:0]         put_data,
    input  logic                                pop,
    output irtx_pkg::queue_status_t             status,
    output logic [irtx_pkg::DATA_W-1:0]         head
);

    logic [irtx_pkg::DATA_W-1:0] store_reg [irtx_pkg::QUEUE_DEPTH];
    logic [irtx_pkg::IDX_W-1:0]  wr_idx_reg;
    logic [irtx_pkg::IDX_W-1:0]  wr_idx_next;
    logic [irtx_pkg::IDX_W-1:0]  rd_idx_reg;
    logic [irtx_pkg::IDX_W-1:0]  rd_idx_next;
    logic [irtx_pkg::IDX_W-1:0]  wr_idx_inc;

    assign wr_idx_inc   = irtx_pkg::next_index(wr_idx_reg);
    assign status.empty = (rd_idx_reg == wr_idx_reg);
    assign status.full  = (wr_idx_inc == rd_idx_reg);
    assign head         = store_reg[rd_idx_reg];

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        if (put && !status.full)
        begin
            wr_idx_next = wr_idx_inc;
        end
        if (pop)
        begin
            rd_idx_next = irtx_pkg::next_index(rd_idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // A put into a full queue lands in the free entry, which is outside the queue.
    always_ff @(posedge clk)
    begin
        if (put)
        begin
            store_reg[wr_idx_reg] <= put_data;
        end
    end

endmodule

// ===== rtl/irtx_slot_seq.sv =====
// ----------------------------------------------------------------------------
// irtx_slot_seq
// Slot counter that frames a byte and drives the burst pattern per tick.
// ----------------------------------------------------------------------------
module irtx_slot_seq
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick,
    input  irtx_pkg::queue_status_t             q_status,
    input  logic [irtx_pkg::DATA_W-1:0]         q_head,
    output logic                                pop,
    output irtx_pkg::slot_status_t              status
);

    logic [irtx_pkg::COUNT_W-1:0] count_reg;
    logic [irtx_pkg::COUNT_W-1:0] count_next;
    logic [irtx_pkg::FRAME_W-1:0] frame_reg;
    logic [irtx_pkg::FRAME_W-1:0] frame_next;
    logic                         active_reg;
    logic                         active_next;
    logic                         carrier_reg;
    logic                         carrier_next;
    logic                         frame_bit;

    assign frame_bit = frame_reg[count_reg[5:2]];

    always_comb
    begin
        count_next   = count_reg;
        frame_next   = frame_reg;
        active_next  = active_reg;
        carrier_next = carrier_reg;
        pop          = 1'b0;
        if (tick)
        begin
            if (count_reg == '0)
            begin
                carrier_next = 1'b0;
                active_next  = 1'b0;
                if (!q_status.empty)
                begin
                    frame_next  = irtx_pkg::build_frame(q_head);
                    pop         = 1'b1;
                    count_next  = irtx_pkg::LOAD_COUNT;
                    active_next = 1'b1;
                end
            end
            else
            begin
                if (count_reg >= irtx_pkg::START_TOP || !count_reg[0])
                begin
                    carrier_next = 1'b0;
                end
                else if (count_reg >= irtx_pkg::START_END)
                begin
                    carrier_next = 1'b1;
                end
                else
                begin
                    // Odd counts: burst first half for a one, second half for a zero.
                    carrier_next = count_reg[1] ? (frame_bit | carrier_reg)
                                                : (!frame_bit | carrier_reg);
                end
                count_next = count_reg - 1'b1;
            end
        end
    end

    assign status.burst  = carrier_next;
    assign status.active = active_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            frame_reg   <= '0;
            active_reg  <= 1'b0;
            carrier_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            frame_reg   <= frame_next;
            active_reg  <= active_next;
            carrier_reg <= carrier_next;
        end
    end

endmodule
